// ===== rtl/jtsm_pkg.sv =====
`timescale 1ns / 1ps
package jtsm_pkg;

    localparam int unsigned NUM_BUCKETS_DEF = 16;
    localparam logic [31:0] DEADLINE_RST    = 32'd32000;
    localparam logic [32:0] US_ROUND        = 33'd16;
    localparam int unsigned US_SHIFT        = 5;

    typedef enum logic [1:0] {
        DIV_BUCKET = 2'd0,
        DIV_MRESP  = 2'd1,
        DIV_MJIT   = 2'd2
    } t_div_sel;

    typedef struct packed {
        logic     load;
        logic     update;
        logic     div_start;
        t_div_sel div_sel;
        logic     cap_bucket;
        logic     cap_mresp;
        logic     cap_mjit;
        logic     ram_rd;
        logic     ram_wr;
        logic     out_load;
    } t_cmd;

    typedef struct packed {
        logic div_done;
    } t_stat;

endpackage

// ===== rtl/jtsm_ram.sv =====
`timescale 1ns / 1ps
module jtsm_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/jtsm_div.sv =====
`timescale 1ns / 1ps
module jtsm_div #(
    parameter int unsigned DW = 37
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_num,
    input  logic [31:0]   i_den,
    output logic          o_done,
    output logic [DW-1:0] o_quot
);
    localparam int unsigned CW = $clog2(DW);

    logic [DW-1:0] r_num;
    logic [31:0]   r_rem;
    logic [31:0]   r_den;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [32:0]   rem_sh;
    logic          ge;

    // one quotient bit per cycle, restoring
    assign rem_sh = {r_rem, r_num[DW-1]};
    assign ge     = rem_sh >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(DW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_num <= {r_num[DW-2:0], ge};
            r_rem <= ge ? 32'(rem_sh - {1'b0, r_den}) : rem_sh[31:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_num;
endmodule

// ===== rtl/jtsm_dp.sv =====
`timescale 1ns / 1ps
module jtsm_dp #(
    parameter int unsigned NUM_BUCKETS = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  jtsm_pkg::t_cmd  i_cmd,
    output jtsm_pkg::t_stat o_stat,
    input  logic            i_cfg_we,
    input  logic [31:0]     i_cfg_data,
    input  logic [31:0]     i_release_time,
    input  logic [31:0]     i_start_time,
    input  logic [31:0]     i_completion_time,
    output logic [31:0]     o_job_count,
    output logic [27:0]     o_min_response_us,
    output logic [27:0]     o_max_response_us,
    output logic [31:0]     o_mean_response_us,
    output logic [27:0]     o_min_jitter_us,
    output logic [27:0]     o_max_jitter_us,
    output logic [31:0]     o_mean_jitter_us,
    output logic [31:0]     o_miss_count,
    output logic            o_missed_now,
    output logic [3:0]      o_bucket_index,
    output logic [31:0]     o_bucket_count
);
    import jtsm_pkg::*;

    localparam int unsigned MW  = $clog2(NUM_BUCKETS + 1);
    localparam int unsigned DW  = 32 + MW;
    localparam int unsigned BIW = $clog2(NUM_BUCKETS);

    logic [31:0]  r_deadline;
    logic [31:0]  r_resp;
    logic [31:0]  r_jit;
    logic [31:0]  r_jobs;
    logic [27:0]  r_rmin, r_rmax, r_jmin, r_jmax;
    logic [31:0]  r_rtot, r_jtot;
    logic [31:0]  r_misses;
    logic         r_missed;
    logic         r_sat;
    logic [BIW-1:0] r_bucket;
    logic [31:0]  r_mresp, r_mjit;
    logic [31:0]  r_bcount;
    logic [NUM_BUCKETS-1:0] r_bvalid;

    logic [27:0]  resp_us, jit_us;
    logic [DW-1:0] div_num;
    logic [31:0]  div_den;
    logic         div_done;
    logic [DW-1:0] div_q;
    logic [31:0]  ram_rdata;
    logic [31:0]  n_bcount;

    assign resp_us = 28'((33'(r_resp) + US_ROUND) >> US_SHIFT);
    assign jit_us  = 28'((33'(r_jit) + US_ROUND) >> US_SHIFT);

    always_comb begin
        case (i_cmd.div_sel)
            DIV_BUCKET: begin
                div_num = DW'(r_resp) * DW'(NUM_BUCKETS);
                div_den = r_deadline;
            end
            DIV_MRESP: begin
                div_num = DW'(r_rtot);
                div_den = r_jobs;
            end
            DIV_MJIT: begin
                div_num = DW'(r_jtot);
                div_den = r_jobs;
            end
            default: begin
                div_num = '0;
                div_den = r_jobs;
            end
        endcase
    end

    jtsm_div #(.DW(DW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_q)
    );

    assign o_stat.div_done = div_done;

    assign n_bcount = r_bvalid[r_bucket] ? ram_rdata + 32'd1 : 32'd1;

    jtsm_ram #(.WIDTH(32), .DEPTH(NUM_BUCKETS)) u_hist (
        .i_clk   (i_clk),
        .i_we    (i_cmd.ram_wr),
        .i_waddr (r_bucket),
        .i_wdata (n_bcount),
        .i_re    (i_cmd.ram_rd),
        .i_raddr (r_bucket),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deadline <= DEADLINE_RST;
            r_jobs     <= '0;
            r_rmin     <= '1;
            r_rmax     <= '0;
            r_rtot     <= '0;
            r_jmin     <= '1;
            r_jmax     <= '0;
            r_jtot     <= '0;
            r_misses   <= '0;
            r_bvalid   <= '0;
        end else begin
            if (i_cfg_we) begin
                r_deadline <= i_cfg_data;
            end
            if (i_cmd.update) begin
                r_jobs <= r_jobs + 32'd1;
                if (resp_us < r_rmin) r_rmin <= resp_us;
                if (resp_us > r_rmax) r_rmax <= resp_us;
                r_rtot <= r_rtot + 32'(resp_us);
                if (jit_us < r_jmin) r_jmin <= jit_us;
                if (jit_us > r_jmax) r_jmax <= jit_us;
                r_jtot <= r_jtot + 32'(jit_us);
                if (r_resp > r_deadline) r_misses <= r_misses + 32'd1;
            end
            if (i_cmd.ram_wr) begin
                r_bvalid[r_bucket] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_resp <= i_completion_time - i_release_time;
            r_jit  <= i_start_time - i_release_time;
        end
        if (i_cmd.update) begin
            r_missed <= r_resp > r_deadline;
            // also covers a zero deadline
            r_sat    <= r_resp >= r_deadline;
        end
        if (i_cmd.cap_bucket) begin
            r_bucket <= r_sat ? BIW'(NUM_BUCKETS - 1) : div_q[BIW-1:0];
        end
        if (i_cmd.cap_mresp) begin
            r_mresp <= (r_jobs == '0) ? '0 : div_q[31:0];
        end
        if (i_cmd.cap_mjit) begin
            r_mjit <= (r_jobs == '0) ? '0 : div_q[31:0];
        end
        if (i_cmd.ram_wr) begin
            r_bcount <= n_bcount;
        end
        if (i_cmd.out_load) begin
            o_job_count        <= r_jobs;
            o_min_response_us  <= r_rmin;
            o_max_response_us  <= r_rmax;
            o_mean_response_us <= r_mresp;
            o_min_jitter_us    <= r_jmin;
            o_max_jitter_us    <= r_jmax;
            o_mean_jitter_us   <= r_mjit;
            o_miss_count       <= r_misses;
            o_missed_now       <= r_missed;
            o_bucket_index     <= 4'(r_bucket);
            o_bucket_count     <= r_bcount;
        end
    end
endmodule

// ===== rtl/jtsm_ctrl.sv =====
`timescale 1ns / 1ps
module jtsm_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output jtsm_pkg::t_cmd  o_cmd,
    input  jtsm_pkg::t_stat i_stat
);
    import jtsm_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_UPD  = 7'b0000010,
        S_DIVB = 7'b0000100,
        S_DIVR = 7'b0001000,
        S_DIVJ = 7'b0010000,
        S_WR   = 7'b0100000,
        S_OUT  = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic   r_ovalid, n_ovalid;
    logic   out_free;

    assign out_free   = !r_ovalid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign o_out_valid = r_ovalid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.div_sel = DIV_BUCKET;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                o_cmd.update    = 1'b1;
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_BUCKET;
                n_state = S_DIVB;
            end
            S_DIVB: begin
                if (i_stat.div_done) begin
                    o_cmd.cap_bucket = 1'b1;
                    o_cmd.div_start  = 1'b1;
                    o_cmd.div_sel    = DIV_MRESP;
                    n_state = S_DIVR;
                end
            end
            S_DIVR: begin
                o_cmd.div_sel = DIV_MJIT;
                if (i_stat.div_done) begin
                    o_cmd.cap_mresp = 1'b1;
                    o_cmd.div_start = 1'b1;
                    n_state = S_DIVJ;
                end
            end
            S_DIVJ: begin
                if (i_stat.div_done) begin
                    o_cmd.cap_mjit = 1'b1;
                    o_cmd.ram_rd   = 1'b1;
                    n_state = S_WR;
                end
            end
            S_WR: begin
                o_cmd.ram_wr = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_ovalid = r_ovalid;
        if (o_cmd.out_load) begin
            n_ovalid = 1'b1;
        end else if (!i_out_stall) begin
            n_ovalid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    a_accept_upd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_in_valid) |=> (r_state == S_UPD))
        else $error("accepted word did not start an update");

    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_stat.div_done |-> (r_state == S_DIVB || r_state == S_DIVR || r_state == S_DIVJ))
        else $error("divider finished outside a divide state");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && r_ovalid && i_out_stall) |=> (r_state == S_OUT))
        else $error("result overwrote a stalled word");
endmodule

// ===== rtl/job_timing_statistics_monitor_top.sv =====
`timescale 1ns / 1ps
// job timing statistics monitor
// input channel: one job record (release, start, completion tick stamps) per word,
// taken when i_in_valid is high and o_in_stall is low.
// output channel: one statistics word per job, taken when o_out_valid is high
// and i_out_stall is low; the fields stay stable while stalled.
// i_cfg_we writes i_cfg_data into the deadline register; write only while idle.
// a single bit-serial divider computes the bucket and both means in turn for each job.
// one job is in work at a time; the next is taken once the previous result has
// moved into the output register, so a waiting result does not block input.
// when the receiver stalls, a finished job waits in place until the output
// register frees.
// reset (synchronous, active low) clears the counts, minima, maxima and sums, the
// histogram valid bits and the output valid, and sets the deadline to 32000 ticks.
module job_timing_statistics_monitor_top #(
    parameter int unsigned NUM_BUCKETS = jtsm_pkg::NUM_BUCKETS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [31:0] i_release_time,
    input  logic [31:0] i_start_time,
    input  logic [31:0] i_completion_time,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_job_count,
    output logic [27:0] o_min_response_us,
    output logic [27:0] o_max_response_us,
    output logic [31:0] o_mean_response_us,
    output logic [27:0] o_min_jitter_us,
    output logic [27:0] o_max_jitter_us,
    output logic [31:0] o_mean_jitter_us,
    output logic [31:0] o_miss_count,
    output logic        o_missed_now,
    output logic [3:0]  o_bucket_index,
    output logic [31:0] o_bucket_count
);
    import jtsm_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    jtsm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    jtsm_dp #(.NUM_BUCKETS(NUM_BUCKETS)) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_stat             (stat),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_data         (i_cfg_data),
        .i_release_time     (i_release_time),
        .i_start_time       (i_start_time),
        .i_completion_time  (i_completion_time),
        .o_job_count        (o_job_count),
        .o_min_response_us  (o_min_response_us),
        .o_max_response_us  (o_max_response_us),
        .o_mean_response_us (o_mean_response_us),
        .o_min_jitter_us    (o_min_jitter_us),
        .o_max_jitter_us    (o_max_jitter_us),
        .o_mean_jitter_us   (o_mean_jitter_us),
        .o_miss_count       (o_miss_count),
        .o_missed_now       (o_missed_now),
        .o_bucket_index     (o_bucket_index),
        .o_bucket_count     (o_bucket_count)
    );
endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;

    localparam int unsigned NBK = 16;

    typedef struct packed {
        logic [31:0] rel;
        logic [31:0] sta;
        logic [31:0] cmp;
    } t_job;

    typedef struct packed {
        logic [31:0] job_count;
        logic [27:0] min_resp;
        logic [27:0] max_resp;
        logic [31:0] mean_resp;
        logic [27:0] min_jit;
        logic [27:0] max_jit;
        logic [31:0] mean_jit;
        logic [31:0] miss_count;
        logic        missed;
        logic [3:0]  bucket;
        logic [31:0] bucket_count;
    } t_stats;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic [31:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [31:0] rel_t, sta_t, cmp_t;
    logic        out_valid;
    logic        out_stall;
    t_stats      act;

    job_timing_statistics_monitor_top #(.NUM_BUCKETS(NBK)) uut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_we(cfg_we), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .o_in_stall(in_stall),
        .i_release_time(rel_t), .i_start_time(sta_t), .i_completion_time(cmp_t),
        .o_out_valid(out_valid), .i_out_stall(out_stall),
        .o_job_count(act.job_count), .o_min_response_us(act.min_resp),
        .o_max_response_us(act.max_resp), .o_mean_response_us(act.mean_resp),
        .o_min_jitter_us(act.min_jit), .o_max_jitter_us(act.max_jit),
        .o_mean_jitter_us(act.mean_jit), .o_miss_count(act.miss_count),
        .o_missed_now(act.missed), .o_bucket_index(act.bucket),
        .o_bucket_count(act.bucket_count)
    );

    // predictor state
    logic [31:0] deadline;
    logic [31:0] n_jobs, r_min, r_max, r_sum, j_min, j_max, j_sum, n_miss;
    logic [31:0] hist [NBK];

    t_job   pending_jobs [$];
    t_stats expected_stats [$];
    int     idle_pct;
    int     stall_pct;
    int     errors;

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic logic [31:0] ticks_to_us(logic [31:0] t);
        logic [32:0] s;
        s = {1'b0, t} + 33'd16;
        return 32'(s >> 5);
    endfunction

    task automatic predict_job(t_job j);
        logic [31:0] rt, jt, ru, ju, bk;
        logic [37:0] prod;
        t_stats e;
        rt = j.cmp - j.rel;
        jt = j.sta - j.rel;
        ru = ticks_to_us(rt);
        ju = ticks_to_us(jt);
        n_jobs = n_jobs + 1;
        if (ru < r_min) r_min = ru;
        if (ru > r_max) r_max = ru;
        r_sum = r_sum + ru;
        if (ju < j_min) j_min = ju;
        if (ju > j_max) j_max = ju;
        j_sum = j_sum + ju;
        e.missed = rt > deadline;
        if (e.missed) n_miss = n_miss + 1;
        if (deadline == 0) begin
            bk = NBK - 1;
        end else begin
            prod = {6'd0, rt} * NBK;
            prod = prod / deadline;
            bk = (prod >= NBK) ? NBK - 1 : 32'(prod);
        end
        hist[bk] = hist[bk] + 1;
        e.job_count = n_jobs;
        e.min_resp = r_min[27:0];
        e.max_resp = r_max[27:0];
        e.mean_resp = (n_jobs == 0) ? 32'd0 : r_sum / n_jobs;
        e.min_jit = j_min[27:0];
        e.max_jit = j_max[27:0];
        e.mean_jit = (n_jobs == 0) ? 32'd0 : j_sum / n_jobs;
        e.miss_count = n_miss;
        e.bucket = bk[3:0];
        e.bucket_count = hist[bk];
        expected_stats.push_back(e);
    endtask

    // driver
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || !in_stall) begin
            if (pending_jobs.size() > 0 && $urandom_range(99) >= idle_pct) begin
                t_job j;
                j = pending_jobs.pop_front();
                predict_job(j);
                in_valid <= 1'b1;
                rel_t <= j.rel;
                sta_t <= j.sta;
                cmp_t <= j.cmp;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (expected_stats.size() == 0) begin
                $error("unexpected word: job_count %0d", act.job_count);
                errors++;
            end else begin
                t_stats e;
                e = expected_stats.pop_front();
                if (e.job_count !== act.job_count) begin
                    $error("job_count exp %h got %h", e.job_count, act.job_count); errors++;
                end
                if (e.min_resp !== act.min_resp) begin
                    $error("min_response_us exp %h got %h", e.min_resp, act.min_resp); errors++;
                end
                if (e.max_resp !== act.max_resp) begin
                    $error("max_response_us exp %h got %h", e.max_resp, act.max_resp); errors++;
                end
                if (e.mean_resp !== act.mean_resp) begin
                    $error("mean_response_us exp %h got %h", e.mean_resp, act.mean_resp);
                    errors++;
                end
                if (e.min_jit !== act.min_jit) begin
                    $error("min_jitter_us exp %h got %h", e.min_jit, act.min_jit); errors++;
                end
                if (e.max_jit !== act.max_jit) begin
                    $error("max_jitter_us exp %h got %h", e.max_jit, act.max_jit); errors++;
                end
                if (e.mean_jit !== act.mean_jit) begin
                    $error("mean_jitter_us exp %h got %h", e.mean_jit, act.mean_jit); errors++;
                end
                if (e.miss_count !== act.miss_count) begin
                    $error("miss_count exp %h got %h", e.miss_count, act.miss_count); errors++;
                end
                if (e.missed !== act.missed) begin
                    $error("missed_now exp %h got %h", e.missed, act.missed); errors++;
                end
                if (e.bucket !== act.bucket) begin
                    $error("bucket_index exp %h got %h", e.bucket, act.bucket); errors++;
                end
                if (e.bucket_count !== act.bucket_count) begin
                    $error("bucket_count exp %h got %h", e.bucket_count, act.bucket_count);
                    errors++;
                end
            end
        end
        if (rst_n) out_stall <= ($urandom_range(99) < stall_pct);
    end

    task automatic add_job(logic [31:0] r, logic [31:0] s, logic [31:0] c);
        t_job j;
        j.rel = r; j.sta = s; j.cmp = c;
        pending_jobs.push_back(j);
    endtask

    task automatic add_random_job(logic [31:0] span);
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(3))
            0: add_job($urandom, $urandom, $urandom);
            default: add_job(r, r + $urandom_range(0, span), r + $urandom_range(0, span));
        endcase
    endtask

    // wait until all words are out, then let the divider settle
    task automatic drain();
        while (pending_jobs.size() > 0 || expected_stats.size() > 0 || in_valid)
            @(posedge clk);
        repeat (150) @(posedge clk);
    endtask

    task automatic set_deadline(logic [31:0] d);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_data <= d;
        @(posedge clk);
        cfg_we <= 1'b0;
        deadline = d;
    endtask

    initial begin
        logic [31:0] dls [6];
        errors = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_data = '0;
        in_valid = 1'b0;
        out_stall = 1'b0;
        rel_t = '0; sta_t = '0; cmp_t = '0;
        idle_pct = 0;
        stall_pct = 0;
        deadline = 32'd32000;
        n_jobs = 0; r_min = '1; r_max = 0; r_sum = 0;
        j_min = '1; j_max = 0; j_sum = 0; n_miss = 0;
        foreach (hist[i]) hist[i] = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed: reset deadline, extremes, wrap-around stamps
        add_job(0, 0, 0);
        add_job('1, '1, '1);
        add_job(0, '1, '1);
        add_job('1, 0, 32'd31999);
        add_job(100, 115, 116);
        add_job(100, 116, 32'd32100);
        add_job(100, 117, 32'd32101);
        add_job(32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5555);
        add_job(32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA);
        add_job(0, 32'h8000_0000, 32'h7FFF_FFFF);
        drain();
        // zero deadline: all nonzero responses miss, last bucket
        set_deadline(0);
        add_job(5, 5, 5);
        add_job(5, 6, 6);
        add_job(7, 3, 2);
        drain();
        set_deadline('1);
        add_job(0, 0, '1);
        add_job(0, 0, 32'hFFFF_FFFE);
        add_job(0, 0, 32'h0FFF_FFFF);
        drain();
        set_deadline(1);
        add_job(0, 0, 1);
        add_job(0, 0, 2);
        add_job(9, 9, 9);
        drain();

        dls = '{32'd32000, 32'd1000, 32'd1, 32'd0, 32'hFFFF_FFFF, 32'd250000};
        for (int ph = 0; ph < 6; ph++) begin
            logic [31:0] span;
            set_deadline(ph == 2 ? 32'd16 : dls[ph]);
            span = (deadline == 0 || deadline > 32'h1000_0000) ? '1 : deadline * 2;
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 72; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 72; end
                default: begin idle_pct = 24; stall_pct = 24; end
            endcase
            for (int k = 0; k < 170; k++) add_random_job(span);
            // hold off once until the block runs dry
            while (pending_jobs.size() > 85) @(posedge clk);
            if (ph == 1) begin
                idle_pct = 100;
                while (expected_stats.size() > 0) @(posedge clk);
                idle_pct = 72;
            end
            drain();
        end
        if (errors == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("tb_top: FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/jtsm_pkg.sv
rtl/jtsm_ram.sv
rtl/jtsm_div.sv
rtl/jtsm_dp.sv
rtl/jtsm_ctrl.sv
rtl/job_timing_statistics_monitor_top.sv
test/tb_top.sv
